// File: rtl/core/lgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared sizes, register indexes, operation codes and controller states of
// the life grid generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 32;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int GW_W  = 8;
    localparam int GH_W  = 6;
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 8;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [GW_W-1:0] GRID_WIDTH_RESET  = GW_W'(MAX_WIDTH);
    localparam logic [GH_W-1:0] GRID_HEIGHT_RESET = GH_W'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_ADV_FIRST,
        ST_ADV_ROW,
        ST_RESP
    } state_t;

endpackage

// File: rtl/core/life_grid_generation_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Game of Life grid (B3/S23, no wrap) with single-cell access and a
// whole-grid generation step, kept in a row-wide synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one command per beat: s_tuser selects write,
// read or advance, s_tdata carries row, column and the new cell state.
// Code 3 is accepted and dropped. Every other command returns one master
// beat: cell_out in m_tdata, step_done and out_of_range in m_tuser.
// An out-of-range read or write answers in the cycle after acceptance
// when the output register is free, and the block then takes a new
// command at once. An in-range read or write reads the row from memory
// in ST_ACCESS and then answers; no new command is taken meanwhile. An
// advance sweeps the rows in use one per cycle (one memory read and one
// write each) and then answers; no command is taken meanwhile either.
// A finished beat waits in the output register while the next command is
// taken; when the receiver stalls a second finished beat, the block holds
// it and takes no further command. Reset empties the grid at once
// through per-row valid bits and sets width 128 and height 32.
// Configuration is to be written only while the block is idle.
// ----------------------------------------------------------------------------
module life_grid_generation_step (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lgs_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [lgs_pkg::CFG_DW-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row [4:0], column [11:5], cell_in [12], zero above
    input  logic [lgs_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation [1:0]
    input  logic [lgs_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cell_out [0], zero above
    output logic [lgs_pkg::M_TDATA_W-1:0]  m_tdata,
    // step_done [0], out_of_range [1]
    output logic [lgs_pkg::M_TUSER_W-1:0]  m_tuser
);
    import lgs_pkg::*;

    logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

    state_t               state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic                 cell_reg, cell_next;
    logic [ROW_W-1:0]     y_reg, y_next;
    logic [MAX_WIDTH-1:0] old_reg, old_next;
    logic [MAX_WIDTH-1:0] cur_reg, cur_next;
    logic                 res_cell_reg, res_cell_next;
    logic                 res_step_reg, res_step_next;
    logic                 res_oor_reg, res_oor_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_cell_reg, m_cell_next;
    logic                 m_step_reg, m_step_next;
    logic                 m_oor_reg, m_oor_next;
    logic [GW_W-1:0]      grid_width_reg;
    logic [GH_W-1:0]      grid_height_reg;
    logic [MAX_HEIGHT-1:0] valid_reg;
    logic [MAX_WIDTH-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [MAX_WIDTH-1:0] wr_data;

    logic [GW_W-1:0]      w_use;
    logic [GH_W-1:0]      h_use;
    logic [MAX_WIDTH-1:0] col_mask;
    logic [MAX_WIDTH-1:0] row_data;
    logic [MAX_WIDTH-1:0] nxt_row;
    logic [MAX_WIDTH-1:0] new_gen;
    logic [MAX_WIDTH-1:0] merged_row;
    logic                 slot_free;
    logic                 fin;
    logic                 fin_cell, fin_step, fin_oor;
    logic [ROW_W-1:0]     in_row;
    logic [COL_W-1:0]     in_col;
    logic                 in_cell;
    logic                 in_inside;
    logic [GH_W-1:0]      y_plus1;
    logic [GH_W-1:0]      y_plus2;

    assign in_row  = s_tdata[ROW_W-1:0];
    assign in_col  = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_cell = s_tdata[ROW_W+COL_W];

    always_comb begin
        if (grid_width_reg == '0) begin
            w_use = GW_W'(1);
        end else if (grid_width_reg > GW_W'(MAX_WIDTH)) begin
            w_use = GW_W'(MAX_WIDTH);
        end else begin
            w_use = grid_width_reg;
        end
        if (grid_height_reg == '0) begin
            h_use = GH_W'(1);
        end else if (grid_height_reg > GH_W'(MAX_HEIGHT)) begin
            h_use = GH_W'(MAX_HEIGHT);
        end else begin
            h_use = grid_height_reg;
        end
    end

    assign col_mask  = ~({MAX_WIDTH{1'b1}} << w_use);
    assign in_inside = (GH_W'(in_row) < h_use) && (GW_W'(in_col) < w_use);
    assign row_data  = rd_vld_reg ? rd_data_reg : '0;
    assign y_plus1   = GH_W'(y_reg) + GH_W'(1);
    assign y_plus2   = GH_W'(y_reg) + GH_W'(2);
    assign nxt_row   = (y_plus1 < h_use) ? row_data : '0;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        logic [MAX_WIDTH-1:0] a;
        logic [MAX_WIDTH-1:0] b;
        logic [MAX_WIDTH-1:0] c;
        logic [MAX_WIDTH-1:0] al, ar, bl, br, cl, cr;
        logic [3:0]           cnt;
        a  = old_reg & col_mask;
        b  = cur_reg & col_mask;
        c  = nxt_row & col_mask;
        al = a << 1;
        ar = a >> 1;
        bl = b << 1;
        br = b >> 1;
        cl = c << 1;
        cr = c >> 1;
        for (int x = 0; x < MAX_WIDTH; x++) begin
            cnt = 4'(al[x]) + 4'(a[x]) + 4'(ar[x]) + 4'(bl[x]) + 4'(br[x])
                + 4'(cl[x]) + 4'(c[x]) + 4'(cr[x]);
            new_gen[x] = (cnt == 4'd3) || ((cnt == 4'd2) && cur_reg[x]);
        end
    end

    assign merged_row = (new_gen & col_mask) | (cur_reg & ~col_mask);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cell_next     = cell_reg;
        y_next        = y_reg;
        old_next      = old_reg;
        cur_next      = cur_reg;
        res_cell_next = res_cell_reg;
        res_step_next = res_step_reg;
        res_oor_next  = res_oor_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_cell_next   = m_cell_reg;
        m_step_next   = m_step_reg;
        m_oor_next    = m_oor_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        fin           = 1'b0;
        fin_cell      = 1'b0;
        fin_step      = 1'b0;
        fin_oor       = 1'b0;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    row_next  = in_row;
                    col_next  = in_col;
                    cell_next = in_cell;
                    unique case (s_tuser)
                        OP_WRITE, OP_READ: begin
                            if (in_inside) begin
                                rd_en      = 1'b1;
                                rd_addr    = in_row;
                                state_next = ST_ACCESS;
                            end else begin
                                fin     = 1'b1;
                                fin_oor = 1'b1;
                            end
                        end
                        OP_ADVANCE: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            y_next     = '0;
                            state_next = ST_ADV_FIRST;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ACCESS: begin
                fin = 1'b1;
                if (op_reg == OP_WRITE) begin
                    wr_en            = 1'b1;
                    wr_addr          = row_reg;
                    wr_data          = row_data;
                    wr_data[col_reg] = cell_reg;
                end else begin
                    fin_cell = row_data[col_reg];
                end
            end
            ST_ADV_FIRST: begin
                cur_next = row_data;
                old_next = '0;
                if (y_plus1 < h_use) begin
                    rd_en   = 1'b1;
                    rd_addr = ROW_W'(y_plus1);
                end
                state_next = ST_ADV_ROW;
            end
            ST_ADV_ROW: begin
                wr_en    = 1'b1;
                wr_addr  = y_reg;
                wr_data  = merged_row;
                old_next = cur_reg;
                cur_next = nxt_row;
                if (y_plus1 < h_use) begin
                    y_next = ROW_W'(y_plus1);
                    if (y_plus2 < h_use) begin
                        rd_en   = 1'b1;
                        rd_addr = ROW_W'(y_plus2);
                    end
                end else begin
                    fin      = 1'b1;
                    fin_step = 1'b1;
                    y_next   = '0;
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_cell_next   = res_cell_reg;
                    m_step_next   = res_step_reg;
                    m_oor_next    = res_oor_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin) begin
            if (slot_free) begin
                m_tvalid_next = 1'b1;
                m_cell_next   = fin_cell;
                m_step_next   = fin_step;
                m_oor_next    = fin_oor;
                state_next    = ST_IDLE;
            end else begin
                res_cell_next = fin_cell;
                res_step_next = fin_step;
                res_oor_next  = fin_oor;
                state_next    = ST_RESP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            y_reg           <= '0;
            valid_reg       <= '0;
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            y_reg        <= y_next;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_GRID_WIDTH:  grid_width_reg  <= cfg_wr_data[GW_W-1:0];
                    REG_GRID_HEIGHT: grid_height_reg <= cfg_wr_data[GH_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        cell_reg     <= cell_next;
        old_reg      <= old_next;
        cur_reg      <= cur_next;
        res_cell_reg <= res_cell_next;
        res_step_reg <= res_step_next;
        res_oor_reg  <= res_oor_next;
        m_cell_reg   <= m_cell_next;
        m_step_reg   <= m_step_next;
        m_oor_reg    <= m_oor_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, m_cell_reg};
    assign m_tuser  = {m_oor_reg, m_step_reg};

endmodule

// File: rtl/core/lgs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks of the life grid generation step block, bound to the
// top level.
// ----------------------------------------------------------------------------
module lgs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lgs_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lgs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [lgs_pkg::M_TUSER_W-1:0]  m_tuser
);
    import lgs_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat present after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_advance_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_ADVANCE) |=> !s_tready)
        else $error("command taken during a generation step");

    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tdata[0] && !m_tuser[1])
        else $error("step result carries cell or range flags");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/life_grid_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_result_check
// Watches the command, result and register ports of the life grid block,
// keeps its own copy of the cell grid and the grid size, works out the
// answer each accepted command must produce and compares every result beat
// against the oldest answer still owed. Mismatches and owed answers are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module life_grid_result_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lgs_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [lgs_pkg::CFG_DW-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // row [4:0], column [11:5], cell_in [12], zero above
    input  logic [lgs_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation [1:0]
    input  logic [lgs_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // cell_out [0], zero above
    input  logic [lgs_pkg::M_TDATA_W-1:0]  m_tdata,
    // step_done [0], out_of_range [1]
    input  logic [lgs_pkg::M_TUSER_W-1:0]  m_tuser,
    output int                             mismatch_count,
    output int                             pending_count
);
    import lgs_pkg::*;

    typedef struct packed {
        logic cell_out;
        logic step_done;
        logic out_of_range;
    } answer_t;

    logic [MAX_WIDTH-1:0] cells [MAX_HEIGHT];
    logic [GW_W-1:0]      width_reg;
    logic [GH_W-1:0]      height_reg;
    answer_t              owed_answers[$];
    int                   errors = 0;

    function automatic int clamp_dim(input int value, input int limit);
        return (value < 1) ? 1 : ((value > limit) ? limit : value);
    endfunction

    task automatic report_mismatch(input string text);
        errors++;
        if (errors <= 10) begin
            $display("%0t ns: result mismatch: %s", $time, text);
        end
    endtask

    task automatic predict_command(
        input logic [S_TUSER_W-1:0] op,
        input logic [ROW_W-1:0]     row,
        input logic [COL_W-1:0]     column,
        input logic                 cell_in
    );
        logic [MAX_WIDTH-1:0] prior [MAX_HEIGHT];
        answer_t              answer;
        int                   cols;
        int                   rows;
        int                   live;
        logic                 in_grid;
        cols    = clamp_dim(int'(width_reg), MAX_WIDTH);
        rows    = clamp_dim(int'(height_reg), MAX_HEIGHT);
        in_grid = (int'(row) < rows) && (int'(column) < cols);
        answer  = '0;
        case (op)
            OP_ADVANCE: begin
                // Every cell of the new generation is judged on the old one.
                prior = cells;
                for (int y = 0; y < rows; y++) begin
                    for (int x = 0; x < cols; x++) begin
                        live = 0;
                        for (int dy = -1; dy <= 1; dy++) begin
                            for (int dx = -1; dx <= 1; dx++) begin
                                if ((dy != 0 || dx != 0) && y + dy >= 0 && y + dy < rows
                                        && x + dx >= 0 && x + dx < cols) begin
                                    live += prior[y + dy][x + dx];
                                end
                            end
                        end
                        if (live == 3) begin
                            cells[y][x] = 1'b1;
                        end else if (live != 2) begin
                            cells[y][x] = 1'b0;
                        end
                    end
                end
                answer.step_done = 1'b1;
                owed_answers.push_back(answer);
            end
            OP_WRITE, OP_READ: begin
                if (!in_grid) begin
                    answer.out_of_range = 1'b1;
                end else if (op == OP_WRITE) begin
                    cells[row][column] = cell_in;
                end else begin
                    answer.cell_out = cells[row][column];
                end
                owed_answers.push_back(answer);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            foreach (cells[r]) cells[r] = '0;
            width_reg  = GRID_WIDTH_RESET;
            height_reg = GRID_HEIGHT_RESET;
            owed_answers.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_answers.size() == 0) begin
                    report_mismatch($sformatf("beat m_tdata=%h m_tuser=%b with no command owed",
                                              m_tdata, m_tuser));
                end else begin
                    want = owed_answers.pop_front();
                    if (m_tdata != M_TDATA_W'(want.cell_out) || m_tuser[0] != want.step_done
                            || m_tuser[1] != want.out_of_range) begin
                        report_mismatch($sformatf(
                            "expected cell_out=%0b step_done=%0b out_of_range=%0b, got %s",
                            want.cell_out, want.step_done, want.out_of_range,
                            $sformatf("m_tdata=%h step_done=%0b out_of_range=%0b",
                                      m_tdata, m_tuser[0], m_tuser[1])));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_command(s_tuser, s_tdata[ROW_W-1:0], s_tdata[ROW_W+COL_W-1:ROW_W],
                                s_tdata[ROW_W+COL_W]);
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_GRID_WIDTH:  width_reg  = cfg_wr_data[GW_W-1:0];
                    REG_GRID_HEIGHT: height_reg = cfg_wr_data[GH_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatch_count <= errors;
        pending_count  <= owed_answers.size();
    end

endmodule

// File: verif/tb_life_grid_generation_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_grid_generation_step
// Drives cell writes, cell reads, generation steps and dropped commands into
// the life grid block over a series of grid sizes, from 1x1 up to the full
// 128x32 and through clamped register values. A short directed opening is
// followed by random commands, many of them small seed-step-inspect bursts.
// Both stream sides idle at random; the result side also stalls for a long
// stretch so the block backs up. The result check module does the judging.
// ----------------------------------------------------------------------------
module tb_life_grid_generation_step;
    import lgs_pkg::*;

    localparam logic [S_TUSER_W-1:0] OP_UNUSED = 2'd3;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 40;
    localparam int PHASE_ITEMS      = 116;
    localparam int NUM_SHAPES       = 12;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr    = '0;
    logic [CFG_DW-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    int                   mismatch_count;
    int                   pending_count;

    bit quiet         = 1'b0;
    int holds_asked   = 0;
    int holds_granted = 0;
    int grid_cols     = MAX_WIDTH;
    int grid_rows     = MAX_HEIGHT;
    int n_sent        = 0;
    int n_writes      = 0;
    int n_reads       = 0;
    int n_steps       = 0;
    int n_dropped     = 0;
    int n_shapes      = 1;
    int shape_list [NUM_SHAPES][2] = '{
        '{0, 64}, '{255, 255}, '{3, 3}, '{1, 32}, '{128, 1}, '{129, 5},
        '{9, 45}, '{17, 12}, '{2, 2}, '{0, 0}, '{0, 0}, '{128, 32}
    };

    always #2 aclk = ~aclk;

    life_grid_generation_step i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    life_grid_result_check i_result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (holds_granted != holds_asked) begin
                holds_granted++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_command(
        input logic [S_TUSER_W-1:0] op,
        input int                   row,
        input int                   column,
        input logic                 cell_in
    );
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({cell_in, COL_W'(column), ROW_W'(row)});
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        case (op)
            OP_WRITE:   n_writes++;
            OP_READ:    n_reads++;
            OP_ADVANCE: n_steps++;
            default:    n_dropped++;
        endcase
    endtask

    task automatic configure_grid(input int width_value, input int height_value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_GRID_WIDTH;
        cfg_wr_data <= CFG_DW'(width_value);
        @(posedge aclk);
        cfg_addr    <= REG_GRID_HEIGHT;
        cfg_wr_data <= CFG_DW'(height_value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        grid_cols = (width_value < 1) ? 1 : ((width_value > MAX_WIDTH) ? MAX_WIDTH : width_value);
        grid_rows = height_value % 64;
        grid_rows = (grid_rows < 1) ? 1 : ((grid_rows > MAX_HEIGHT) ? MAX_HEIGHT : grid_rows);
        n_shapes++;
    endtask

    function automatic int pick_row();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_HEIGHT - 1)
                                           : $urandom_range(0, grid_rows - 1);
    endfunction

    function automatic int pick_column();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_WIDTH - 1)
                                           : $urandom_range(0, grid_cols - 1);
    endfunction

    task automatic random_phase(input int count);
        int stop_at;
        int pick;
        int top_row;
        int left_col;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // Seed a small patch, step it, then look at what grew there.
                top_row  = $urandom_range(0, grid_rows - 1);
                left_col = $urandom_range(0, grid_cols - 1);
                for (int dy = 0; dy < 3; dy++) begin
                    for (int dx = 0; dx < 3; dx++) begin
                        send_command(OP_WRITE, top_row + dy, left_col + dx,
                                     $urandom_range(0, 99) < 55);
                    end
                end
                repeat ($urandom_range(1, 2)) begin
                    send_command(OP_ADVANCE, $urandom, $urandom, 1'($urandom));
                end
                for (int dy = -1; dy < 4; dy++) begin
                    for (int dx = -1; dx < 4; dx++) begin
                        send_command(OP_READ, top_row + dy, left_col + dx, 1'($urandom));
                    end
                end
            end else if (pick < 50) begin
                send_command(OP_WRITE, pick_row(), pick_column(), $urandom_range(0, 99) < 40);
            end else if (pick < 85) begin
                send_command(OP_READ, pick_row(), pick_column(), 1'($urandom));
            end else if (pick < 95) begin
                send_command(OP_ADVANCE, $urandom, $urandom, 1'($urandom));
            end else begin
                send_command(OP_UNUSED, $urandom, $urandom, 1'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Corner L-shape and a lone far corner cell on the full grid.
        send_command(OP_WRITE, 0, 0, 1'b1);
        send_command(OP_WRITE, MAX_HEIGHT - 1, MAX_WIDTH - 1, 1'b1);
        send_command(OP_WRITE, 0, 1, 1'b1);
        send_command(OP_WRITE, 1, 0, 1'b1);
        send_command(OP_READ, 0, 0, 1'b0);
        send_command(OP_READ, MAX_HEIGHT - 1, MAX_WIDTH - 1, 1'b1);
        send_command(OP_READ, 5, 64, 1'b0);
        send_command(OP_UNUSED, MAX_HEIGHT - 1, MAX_WIDTH - 1, 1'b1);
        send_command(OP_ADVANCE, 0, 0, 1'b0);
        send_command(OP_READ, 0, 0, 1'b0);
        send_command(OP_READ, 0, 1, 1'b0);
        send_command(OP_READ, 1, 0, 1'b0);
        send_command(OP_READ, 1, 1, 1'b0);
        send_command(OP_READ, MAX_HEIGHT - 1, MAX_WIDTH - 1, 1'b0);
        // A horizontal blinker turns vertical.
        send_command(OP_WRITE, 10, 63, 1'b1);
        send_command(OP_WRITE, 10, 64, 1'b1);
        send_command(OP_WRITE, 10, 65, 1'b1);
        send_command(OP_ADVANCE, 31, 127, 1'b1);
        send_command(OP_READ, 9, 64, 1'b0);
        send_command(OP_READ, 11, 64, 1'b0);
        send_command(OP_READ, 10, 63, 1'b0);
        send_command(OP_WRITE, 0, 0, 1'b0);
        configure_grid(3, 2);
        send_command(OP_READ, 2, 0, 1'b0);
        send_command(OP_WRITE, 0, 3, 1'b1);
        send_command(OP_READ, MAX_HEIGHT - 1, MAX_WIDTH - 1, 1'b0);

        shape_list[9]  = '{$urandom_range(0, 255), $urandom_range(0, 255)};
        shape_list[10] = '{$urandom_range(0, 255), $urandom_range(0, 255)};
        for (int i = 0; i < NUM_SHAPES; i++) begin
            if (i == NUM_SHAPES - 1) begin
                quiet = 1'b1;
            end
            configure_grid(shape_list[i][0], shape_list[i][1]);
            if (i == 1 || i == 6) begin
                holds_asked++;
            end
            random_phase(PHASE_ITEMS);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d commands: %0d cell writes, %0d cell reads, %0d generation steps",
                 n_sent, n_writes, n_reads, n_steps);
        $display("and %0d dropped codes, over %0d grid shapes with long and short result stalls.",
                 n_dropped, n_shapes);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/lgs_pkg.sv
rtl/core/life_grid_generation_step.sv
rtl/core/lgs_checker.sv
verif/life_grid_result_check.sv
verif/tb_life_grid_generation_step.sv
